// ----- rtl/lers_pkg.sv -----
`default_nettype none
package lers_pkg;

  localparam int XW    = 17;
  localparam int YW    = 16;
  localparam int PW    = XW + YW;
  localparam int AREAW = 33;

  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [XW-1:0] WIDTH_RST  = XW'(100000);
  localparam logic [YW-1:0] HEIGHT_RST = YW'(500);

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // one candidate span handed to the area unit
  typedef struct packed {
    logic          vld;
    logic [XW-1:0] left;
    logic [XW-1:0] right;
    logic [YW-1:0] h;
  } lers_span_t;

endpackage
`default_nettype wire

// ----- rtl/lers_area_unit.sv -----
`default_nettype none
module lers_area_unit import lers_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clr,
  input  wire lers_span_t       req,
  output logic [AREAW-1:0]      best,
  output logic                  pending
);

  logic             vld1_r, vld1_nxt;
  logic [XW-1:0]    span1_r, span1_nxt;
  logic [YW-1:0]    h1_r;
  logic             vld2_r, vld2_nxt;
  logic [AREAW-1:0] prod2_r;
  logic [AREAW-1:0] best_r, best_nxt;

  always_comb begin
    vld1_nxt  = req.vld;
    span1_nxt = (req.right > req.left) ? (req.right - req.left) : '0;
    vld2_nxt  = vld1_r;
    best_nxt  = best_r;
    if (clr) begin
      best_nxt = '0;
    end else if (vld2_r && (prod2_r > best_r)) begin
      best_nxt = prod2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      best_r <= '0;
    end else begin
      vld1_r <= vld1_nxt;
      vld2_r <= vld2_nxt;
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span1_r <= span1_nxt;
    h1_r    <= req.h;
    prod2_r <= AREAW'(span1_r) * AREAW'(h1_r);
  end

  assign best    = best_r;
  assign pending = vld1_r | vld2_r;

endmodule
`default_nettype wire

// ----- rtl/largest_empty_rectangle_strip_core.sv -----
`default_nettype none
// Channel   Handshake                 Payload
// input     start & !busy             in_point_x, in_point_y, in_last_point
// result    out_valid (one cycle)     out_max_area
// config    cfg_we                    cfg_index, cfg_wdata
//
// Points are taken one per cycle while loading. The transaction carrying
// in_last_point closes the set: an insertion sort over the point memory,
// then a pass that sends each slab gap to the area unit, two stack passes
// (left bounds, then right bounds with the areas) with pops, and a drain of
// the area unit before out_valid.
// Reset is synchronous (rst_n low); the point memories need no clearing.
// The receiver cannot stall: out_max_area is shown for exactly one cycle.
module largest_empty_rectangle_strip_core import lers_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [XW-1:0]    in_point_x,
  input  wire logic [YW-1:0]    in_point_y,
  input  wire logic             in_last_point,
  output logic                  out_valid,
  output logic [AREAW-1:0]      out_max_area,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [XW-1:0]    cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SORT_LD  = 11'b00000000010,
    S_SORT_KEY = 11'b00000000100,
    S_SORT_CMP = 11'b00000001000,
    S_SLAB_RD  = 11'b00000010000,
    S_SLAB_GET = 11'b00000100000,
    S_SLAB_END = 11'b00001000000,
    S_STK_RD   = 11'b00010000000,
    S_STK_CMP  = 11'b00100000000,
    S_STK_TOP  = 11'b01000000000,
    S_DRAIN    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic          emit_r, emit_nxt;

  logic [XW-1:0] width_r, width_nxt;
  logic [YW-1:0] height_r, height_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic          dir_r, dir_nxt;       // 0: left pass, 1: right pass
  logic [PW-1:0] key_r, key_nxt;
  logic [PW-1:0] tos_r, tos_nxt;       // copy of the stack top
  logic [XW-1:0] prev_r, prev_nxt;

  // point memory, {x, y} so that word order is point order
  logic [PW-1:0] pt_mem [MAX_POINTS];
  logic          pt_we, pt_re;
  logic [AW-1:0] pt_waddr, pt_raddr;
  logic [PW-1:0] pt_wdata, pt_rd_r;

  logic [PW-1:0] stk_mem [MAX_POINTS];
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [PW-1:0] stk_rd_r;

  logic [XW-1:0] lb_mem [MAX_POINTS];
  logic          lb_we, lb_re;
  logic [XW-1:0] lb_wdata, lb_rd_r;

  lers_span_t       au_req;
  logic [AREAW-1:0] au_best;
  logic             au_pending;
  logic             au_clr;

  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [CW-1:0] i_inc, i_dec, j_dec1, j_dec2, d_dec1, d_dec2;
  logic [XW-1:0] cur_x, tos_x;
  logic [YW-1:0] cur_y, tos_y;

  assign px = (in_point_x > width_r) ? width_r : in_point_x;
  assign py = (in_point_y > height_r) ? height_r : in_point_y;

  assign i_inc  = i_r + CW'(1);
  assign i_dec  = i_r - CW'(1);
  assign j_dec1 = j_r - CW'(1);
  assign j_dec2 = j_r - CW'(2);
  assign d_dec1 = depth_r - CW'(1);
  assign d_dec2 = depth_r - CW'(2);

  assign cur_x = pt_rd_r[PW-1:YW];
  assign cur_y = pt_rd_r[YW-1:0];
  assign tos_x = tos_r[PW-1:YW];
  assign tos_y = tos_r[YW-1:0];

  // configuration writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_nxt  = cfg_wdata;
        CFG_HEIGHT: height_nxt = cfg_wdata[YW-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = 1'b0;
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    depth_nxt = depth_r;
    dir_nxt   = dir_r;
    key_nxt   = key_r;
    tos_nxt   = tos_r;
    prev_nxt  = prev_r;

    pt_we     = 1'b0;
    pt_re     = 1'b0;
    pt_waddr  = count_r[AW-1:0];
    pt_raddr  = i_r[AW-1:0];
    pt_wdata  = {px, py};
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = depth_r[AW-1:0];
    stk_raddr = d_dec2[AW-1:0];
    lb_we     = 1'b0;
    lb_re     = 1'b0;
    lb_wdata  = '0;
    au_req    = '0;
    au_clr    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (emit_r) begin
          au_clr = 1'b1;
        end
        // the result cycle still counts as busy: take nothing then
        if (start && !emit_r) begin
          // drop points once the store is full
          if (count_r < CW'(MAX_POINTS)) begin
            pt_we     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          if (in_last_point) begin
            prev_nxt = '0;
            if (count_nxt > CW'(1)) begin
              i_nxt     = CW'(1);
              state_nxt = S_SORT_LD;
            end else begin
              i_nxt     = '0;
              state_nxt = S_SLAB_RD;
            end
          end
        end
      end

      S_SORT_LD: begin
        pt_re     = 1'b1;
        state_nxt = S_SORT_KEY;
      end

      S_SORT_KEY: begin
        key_nxt   = pt_rd_r;
        j_nxt     = i_r;
        pt_re     = 1'b1;
        pt_raddr  = i_dec[AW-1:0];
        state_nxt = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        pt_we    = 1'b1;
        pt_waddr = j_r[AW-1:0];
        if ((j_r != '0) && (key_r < pt_rd_r)) begin
          // shift the larger entry up and look one further down
          pt_wdata = pt_rd_r;
          j_nxt    = j_dec1;
          pt_re    = 1'b1;
          pt_raddr = j_dec2[AW-1:0];
        end else begin
          pt_wdata = key_r;
          if (i_inc == count_r) begin
            i_nxt     = '0;
            state_nxt = S_SLAB_RD;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_SORT_LD;
          end
        end
      end

      S_SLAB_RD: begin
        pt_re     = 1'b1;
        state_nxt = S_SLAB_GET;
      end

      S_SLAB_GET: begin
        au_req.vld   = 1'b1;
        au_req.left  = prev_r;
        au_req.right = cur_x;
        au_req.h     = height_r;
        prev_nxt     = cur_x;
        i_nxt        = i_inc;
        state_nxt    = (i_inc == count_r) ? S_SLAB_END : S_SLAB_RD;
      end

      S_SLAB_END: begin
        au_req.vld   = 1'b1;
        au_req.left  = prev_r;
        au_req.right = width_r;
        au_req.h     = height_r;
        dir_nxt      = 1'b0;
        i_nxt        = '0;
        depth_nxt    = '0;
        state_nxt    = S_STK_RD;
      end

      S_STK_RD: begin
        pt_re     = 1'b1;
        lb_re     = 1'b1;
        state_nxt = S_STK_CMP;
      end

      S_STK_CMP: begin
        if ((depth_r != '0) && (tos_y >= cur_y)) begin
          // pop and fetch the entry below
          depth_nxt = d_dec1;
          stk_re    = 1'b1;
          state_nxt = S_STK_TOP;
        end else begin
          stk_we    = 1'b1;
          tos_nxt   = pt_rd_r;
          depth_nxt = depth_r + CW'(1);
          if (!dir_r) begin
            lb_we    = 1'b1;
            lb_wdata = (depth_r != '0) ? tos_x : '0;
            if (i_inc == count_r) begin
              dir_nxt   = 1'b1;
              i_nxt     = count_r - CW'(1);
              depth_nxt = '0;
            end else begin
              i_nxt = i_inc;
            end
            state_nxt = S_STK_RD;
          end else begin
            au_req.vld   = 1'b1;
            au_req.left  = lb_rd_r;
            au_req.right = (depth_r != '0) ? tos_x : width_r;
            au_req.h     = cur_y;
            if (i_r == '0) begin
              state_nxt = S_DRAIN;
            end else begin
              i_nxt     = i_dec;
              state_nxt = S_STK_RD;
            end
          end
        end
      end

      S_STK_TOP: begin
        tos_nxt   = stk_rd_r;
        state_nxt = S_STK_CMP;
      end

      S_DRAIN: begin
        // wait for the last products to reach the running maximum
        if (!au_pending) begin
          emit_nxt  = 1'b1;
          count_nxt = '0;
          depth_nxt = '0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      emit_r   <= 1'b0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      count_r  <= '0;
      i_r      <= '0;
      j_r      <= '0;
      depth_r  <= '0;
      dir_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      emit_r   <= emit_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      count_r  <= count_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      depth_r  <= depth_nxt;
      dir_r    <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    tos_r  <= tos_nxt;
    prev_r <= prev_nxt;
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rd_r <= pt_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= pt_rd_r;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[i_r[AW-1:0]] <= lb_wdata;
    end
    if (lb_re) begin
      lb_rd_r <= lb_mem[i_r[AW-1:0]];
    end
  end

  lers_area_unit u_area (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (au_clr),
    .req     (au_req),
    .best    (au_best),
    .pending (au_pending)
  );

  assign busy         = (state_r != S_IDLE) || emit_r;
  assign out_valid    = emit_r;
  assign out_max_area = au_best;

endmodule
`default_nettype wire

// ----- dv/largest_empty_rectangle_strip_core_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module largest_empty_rectangle_strip_core_tb;
  import lers_pkg::*;

  localparam int NPTS       = MAX_POINTS_DEF;
  localparam int IDLE_LIMIT = 4000000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [XW-1:0]    in_point_x;
  logic [YW-1:0]    in_point_y;
  logic             in_last_point;
  logic             out_valid;
  logic [AREAW-1:0] out_max_area;
  logic             cfg_we;
  logic             cfg_index;
  logic [XW-1:0]    cfg_wdata;

  largest_empty_rectangle_strip_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_last_point(in_last_point),
    .out_valid    (out_valid),
    .out_max_area (out_max_area),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Shadow of the block's registers and point store
  logic [XW-1:0]    strip_w;
  logic [YW-1:0]    strip_h;
  logic [XW-1:0]    pt_x [NPTS];
  logic [YW-1:0]    pt_y [NPTS];
  int               pt_count;
  logic [AREAW-1:0] area_queue [$];

  int errors;
  int n_sent;
  int n_sets;
  int n_areas;
  int idle_cycles;
  int gap_left;
  int burst_left;

  task automatic report_mismatch(input string what, input logic [AREAW-1:0] got,
                                 input logic [AREAW-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Largest empty rectangle on the strip base for the stored set
  function automatic logic [AREAW-1:0] largest_area();
    logic [XW-1:0] sx [NPTS];
    logic [YW-1:0] sy [NPTS];
    logic [XW-1:0] lb [NPTS];
    int            stk [NPTS];
    int            sp, j, n;
    logic [XW-1:0] kx, rb;
    logic [YW-1:0] ky;
    logic [63:0]   best, cand;
    n = pt_count;
    if (n == 0) return AREAW'(64'(strip_w) * 64'(strip_h));
    for (int i = 0; i < n; i++) begin
      sx[i] = pt_x[i];
      sy[i] = pt_y[i];
    end
    for (int i = 1; i < n; i++) begin
      kx = sx[i]; ky = sy[i]; j = i;
      while (j > 0 && (kx < sx[j-1] || (kx == sx[j-1] && ky < sy[j-1]))) begin
        sx[j] = sx[j-1]; sy[j] = sy[j-1]; j--;
      end
      sx[j] = kx; sy[j] = ky;
    end
    best = 64'(sx[0]) * 64'(strip_h);
    for (int i = 0; i <= n; i++) begin
      rb = (i + 1 < n) ? sx[i+1] : strip_w;
      if (i < n && rb > sx[i]) begin
        cand = 64'(rb - sx[i]) * 64'(strip_h);
        if (cand > best) best = cand;
      end
    end
    sp = 0;
    for (int i = 0; i < n; i++) begin
      while (sp > 0 && sy[stk[sp-1]] >= sy[i]) sp--;
      lb[i] = (sp > 0) ? sx[stk[sp-1]] : '0;
      stk[sp] = i; sp++;
    end
    sp = 0;
    for (int k = n - 1; k >= 0; k--) begin
      while (sp > 0 && sy[stk[sp-1]] >= sy[k]) sp--;
      rb = (sp > 0) ? sx[stk[sp-1]] : strip_w;
      if (rb > lb[k]) begin
        cand = 64'(rb - lb[k]) * 64'(sy[k]);
        if (cand > best) best = cand;
      end
      stk[sp] = k; sp++;
    end
    return AREAW'(best);
  endfunction

  // Drive one point at a falling edge; hold it until accepted, then update
  // the shadow store. Returns at the accepting rising edge.
  task automatic send_point(input logic [XW-1:0] x, input logic [YW-1:0] y,
                            input logic last);
    while (gap_left > 0) begin
      @(negedge clk);
      start <= 1'b0;
      gap_left--;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_last_point <= last;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (pt_count < NPTS) begin
      pt_x[pt_count] = (x > strip_w) ? strip_w : x;
      pt_y[pt_count] = (y > strip_h) ? strip_h : y;
      pt_count++;
    end
    if (last) begin
      area_queue.push_back(largest_area());
      pt_count = 0;
      n_sets++;
    end
    n_sent++;
    // Choose the next gap: bursts with no idling, then a random pause (sometimes none)
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
    end
  endtask

  // Drop start, wait for all areas, let the block settle, then write a register
  task automatic write_reg(input logic idx, input logic [XW-1:0] val);
    @(negedge clk);
    start <= 1'b0;
    while (area_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) strip_w = val;
    else                  strip_h = val[YW-1:0];
  endtask

  task automatic random_set(input int npts, input int xmax, input int ymax);
    for (int i = 0; i < npts; i++)
      send_point(XW'($urandom_range(0, xmax)), YW'($urandom_range(0, ymax)),
                 i == npts - 1);
  endtask

  // Extremes of the fields, clamping and degenerate sets
  task automatic test_directed();
    send_point('0, '0, 1'b1);
    send_point('1, '1, 1'b1);
    send_point(XW'(50000), YW'(100), 1'b0);
    send_point(XW'(50000), YW'(50), 1'b0);
    send_point(XW'(20000), YW'(400), 1'b1);
    send_point(XW'(99999), YW'(499), 1'b0);
    send_point(XW'(1), YW'(1), 1'b1);
    send_point(XW'(0), YW'(65535), 1'b0);
    send_point(XW'(131071), YW'(0), 1'b1);
    for (int i = 0; i < 6; i++) send_point(XW'(10000 * (i + 1)), YW'(100), i == 5);
  endtask

  // Register changes including the extremes and a change mid-set
  task automatic test_registers();
    write_reg(CFG_WIDTH, XW'(131071));
    write_reg(CFG_HEIGHT, XW'(65535));
    send_point(XW'(0), YW'(0), 1'b1);
    send_point('1, '1, 1'b1);
    random_set(8, 131071, 65535);
    write_reg(CFG_WIDTH, XW'(1));
    write_reg(CFG_HEIGHT, XW'(1));
    random_set(5, 3, 3);
    write_reg(CFG_WIDTH, XW'(1000));
    write_reg(CFG_HEIGHT, XW'(300));
    send_point(XW'(900), YW'(200), 1'b0);
    send_point(XW'(950), YW'(250), 1'b0);
    write_reg(CFG_WIDTH, XW'(500));  // points stored earlier lie right of the strip
    send_point(XW'(100), YW'(20), 1'b1);
  endtask

  // Fill the store past its capacity: the overflow points are dropped
  task automatic test_store_full();
    write_reg(CFG_WIDTH, XW'(4000));
    write_reg(CFG_HEIGHT, XW'(60));
    random_set(NPTS + 3, 4500, 70);
  endtask

  // Mostly small random sets, with the bounds varied between phases
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_WIDTH, XW'($urandom_range(1, 131071)));
      write_reg(CFG_HEIGHT, XW'($urandom_range(1, 65535)));
      for (int s = 0; s < 10; s++)
        random_set($urandom_range(1, 10), (s % 3 == 0) ? 131071 : strip_w,
                   (s % 4 == 0) ? 65535 : strip_h);
    end
  endtask

  // Check each strobed area against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_areas++;
      if (area_queue.size() == 0) begin
        report_mismatch("unexpected max_area", out_max_area, '0);
      end else begin
        logic [AREAW-1:0] want;
        want = area_queue.pop_front();
        if (out_max_area !== want) report_mismatch("max_area", out_max_area, want);
      end
    end
  end

  // Watchdog: count cycles with no transaction in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    errors = 0; n_sent = 0; n_sets = 0; n_areas = 0; idle_cycles = 0;
    gap_left = 0; burst_left = 0; pt_count = 0;
    strip_w = WIDTH_RST; strip_h = HEIGHT_RST;
    rst_n = 1'b0; start = 1'b0; in_point_x = '0; in_point_y = '0;
    in_last_point = 1'b0; cfg_we = 1'b0; cfg_index = CFG_WIDTH; cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_registers();
    test_store_full();
    test_random();
    @(negedge clk);
    start <= 1'b0;
    while (area_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d points in %0d sets, %0d areas checked, %0d mismatches",
             n_sent, n_sets, n_areas, errors);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
